// ===== rtl/sfrt_pkg.sv =====
// Shared types for the symbol frequency rank table.
// Used by the rank cells, the top level and the checker; no dependencies.
package sfrt_pkg;

    // Input opcodes
    localparam logic [1:0] OP_COUNT    = 2'd0;
    localparam logic [1:0] OP_READ     = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // Update mode applied to the whole row of cells at once
    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_INC,
        UPD_INS,
        UPD_CLR
    } upd_mode_t;

    // Compare results each cell hands to its neighbors
    typedef struct packed {
        logic lt;   // own key sorts before the broadcast key
        logic gt;   // own key sorts after the broadcast key
    } cell_flags_t;

endpackage

// ===== rtl/symbol_frequency_rank_table.sv =====
// Symbol frequency rank table: each item takes a symbol memory read, then one update
// pass over the row of rank cells; no new item is taken while one is busy or a result stalls.
// A read result is registered and shows the cycle after the update cycle.
// Reset (rst_n low) empties the table at once; no clearing pass is needed.
// Depends on sfrt_pkg and sfrt_cell.
module symbol_frequency_rank_table
    import sfrt_pkg::*;
#(
    parameter int SYMBOL_COUNT = 256,
    parameter int COUNT_WIDTH  = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  symbol,
    input  logic [7:0]  rank,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_symbol,
    output logic [23:0] frequency,
    output logic        valid_res,
    output logic [8:0]  distinct_count
);

    localparam int N  = SYMBOL_COUNT;
    localparam int CW = COUNT_WIDTH;
    localparam int OW = $clog2(N);
    localparam int DW = $clog2(N + 1);
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    // Per-symbol count and first-seen order, with seen flags
    logic [CW+OW-1:0] sym_mem [N];
    logic [N-1:0]     seen_reg, seen_next;
    logic [CW+OW-1:0] mem_rd_reg;
    logic             seen_rd_reg;

    logic        busy_reg;
    logic [1:0]  op_reg;
    logic [7:0]  sym_reg;
    logic [7:0]  rank_reg;
    logic [DW-1:0] distinct_reg, distinct_next;

    logic        out_valid_reg;
    logic [7:0]  out_sym_reg;
    logic [23:0] freq_reg;
    logic        vres_reg;
    logic [8:0]  dcnt_reg;

    upd_mode_t     mode;
    logic [CW-1:0] k_cnt, o_cnt, rd_cnt;
    logic [OW-1:0] k_ord, o_ord, rd_ord;
    logic          sym_in_range;
    logic          mem_we;

    cell_flags_t   c_flags [N];
    logic [7:0]    c_sym   [N];
    logic [CW-1:0] c_cnt   [N];
    logic [OW-1:0] c_ord   [N];

    logic        accept;
    logic [7:0]  rd_sym;
    logic [CW-1:0] rd_freq;
    logic        rank_ok;

    assign accept   = in_valid && in_ready;
    assign in_ready = !busy_reg && (!out_valid_reg || out_ready);

    assign rd_cnt       = mem_rd_reg[CW+OW-1:OW];
    assign rd_ord       = mem_rd_reg[OW-1:0];
    assign sym_in_range = ({1'b0, sym_reg} < (9)'(N));

    // Decide the row update for the item in flight
    always_comb
    begin
        mode          = UPD_NONE;
        k_cnt         = rd_cnt + CW'(1);
        k_ord         = rd_ord;
        o_cnt         = rd_cnt;
        o_ord         = rd_ord;
        mem_we        = 1'b0;
        seen_next     = seen_reg;
        distinct_next = distinct_reg;
        if (busy_reg)
        begin
            unique case (op_reg)
                OP_COUNT:
                begin
                    if (sym_in_range && !seen_rd_reg && distinct_reg < DW'(N))
                    begin
                        mode          = UPD_INS;
                        k_cnt         = CW'(1);
                        k_ord         = distinct_reg[OW-1:0];
                        mem_we        = 1'b1;
                        seen_next[sym_reg[OW-1:0]] = 1'b1;
                        distinct_next = distinct_reg + DW'(1);
                    end
                    else if (sym_in_range && seen_rd_reg && rd_cnt != CNT_MAX)
                    begin
                        mode   = UPD_INC;
                        mem_we = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    mode          = UPD_CLR;
                    seen_next     = '0;
                    distinct_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Row of rank cells
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        cell_flags_t   lf, rf;
        logic [7:0]    ls, rs;
        logic [CW-1:0] lc, rc;
        logic [OW-1:0] lo, ro;
        if (i == 0)
        begin : g_first
            assign lf = '0;
            assign ls = '0;
            assign lc = '0;
            assign lo = '0;
        end
        else
        begin : g_mid_l
            assign lf = c_flags[i-1];
            assign ls = c_sym[i-1];
            assign lc = c_cnt[i-1];
            assign lo = c_ord[i-1];
        end
        if (i == N - 1)
        begin : g_last
            assign rf = '0;
            assign rs = '0;
            assign rc = '0;
            assign ro = '0;
        end
        else
        begin : g_mid_r
            assign rf = c_flags[i+1];
            assign rs = c_sym[i+1];
            assign rc = c_cnt[i+1];
            assign ro = c_ord[i+1];
        end
        sfrt_cell #(.CW(CW), .OW(OW)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .mode        (mode),
            .is_tail     (distinct_reg == DW'(i)),
            .k_sym       (sym_reg),
            .k_cnt       (k_cnt),
            .k_ord       (k_ord),
            .o_cnt       (o_cnt),
            .o_ord       (o_ord),
            .left_flags  (lf),
            .left_sym    (ls),
            .left_cnt    (lc),
            .left_ord    (lo),
            .right_flags (rf),
            .right_sym   (rs),
            .right_cnt   (rc),
            .right_ord   (ro),
            .flags       (c_flags[i]),
            .sym         (c_sym[i]),
            .cnt         (c_cnt[i]),
            .ord         (c_ord[i])
        );
    end

    // Pick the entry at the requested rank
    assign rank_ok = ({1'b0, rank_reg} < 9'(distinct_reg));
    always_comb
    begin
        rd_sym  = '0;
        rd_freq = '0;
        if (rank_ok)
        begin
            rd_sym  = c_sym[rank_reg[OW-1:0]];
            rd_freq = c_cnt[rank_reg[OW-1:0]];
        end
    end

    // Symbol memory: read on accept, write back in the update cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_rd_reg <= sym_mem[symbol[OW-1:0]];
        end
        if (mem_we)
        begin
            sym_mem[sym_reg[OW-1:0]] <= {k_cnt, k_ord};
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= opcode;
            sym_reg     <= symbol;
            rank_reg    <= rank;
            seen_rd_reg <= seen_reg[symbol[OW-1:0]];
        end
    end

    // Control and table bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            seen_reg      <= '0;
            distinct_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg     <= seen_next;
            distinct_reg <= distinct_next;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                busy_reg <= 1'b0;
            end
            if (busy_reg && op_reg == OP_READ)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (busy_reg && op_reg == OP_READ)
        begin
            out_sym_reg <= rd_sym;
            if (CW > 24 && rd_freq > CW'(24'hFFFFFF))
            begin
                freq_reg <= 24'hFFFFFF;
            end
            else
            begin
                freq_reg <= 24'(rd_freq);
            end
            vres_reg <= rank_ok;
            dcnt_reg <= 9'(distinct_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_symbol     = out_sym_reg;
    assign frequency      = freq_reg;
    assign valid_res      = vres_reg;
    assign distinct_count = dcnt_reg;

endmodule

// ===== rtl/sfrt_cell.sv =====
// One rank slot of the sorted frequency list.
// Depends on sfrt_pkg; neighbors are wired up by the top level.
module sfrt_cell
    import sfrt_pkg::*;
#(
    parameter int CW = 24,
    parameter int OW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  upd_mode_t     mode,
    input  logic          is_tail,
    input  logic [7:0]    k_sym,
    input  logic [CW-1:0] k_cnt,
    input  logic [OW-1:0] k_ord,
    input  logic [CW-1:0] o_cnt,
    input  logic [OW-1:0] o_ord,
    input  cell_flags_t   left_flags,
    input  logic [7:0]    left_sym,
    input  logic [CW-1:0] left_cnt,
    input  logic [OW-1:0] left_ord,
    input  cell_flags_t   right_flags,
    input  logic [7:0]    right_sym,
    input  logic [CW-1:0] right_cnt,
    input  logic [OW-1:0] right_ord,
    output cell_flags_t   flags,
    output logic [7:0]    sym,
    output logic [CW-1:0] cnt,
    output logic [OW-1:0] ord
);

    logic          valid_reg, valid_next;
    logic [7:0]    sym_reg, sym_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [OW-1:0] ord_reg, ord_next;
    logic          ge_old;

    // Compare own key against the new and the old broadcast keys
    always_comb
    begin
        flags.lt = valid_reg && ((cnt_reg < k_cnt) || (cnt_reg == k_cnt && ord_reg < k_ord));
        flags.gt = valid_reg && !flags.lt && !(cnt_reg == k_cnt && ord_reg == k_ord);
        ge_old   = valid_reg && !((cnt_reg < o_cnt) || (cnt_reg == o_cnt && ord_reg < o_ord));
    end

    // Select next content: hold, shift from a neighbor, or take the broadcast entry
    always_comb
    begin
        valid_next = valid_reg;
        sym_next   = sym_reg;
        cnt_next   = cnt_reg;
        ord_next   = ord_reg;
        unique case (mode)
            UPD_INC:
            begin
                if (ge_old && right_flags.lt)
                begin
                    sym_next = right_sym;
                    cnt_next = right_cnt;
                    ord_next = right_ord;
                end
                else if (ge_old && flags.lt)
                begin
                    sym_next = k_sym;
                    cnt_next = k_cnt;
                    ord_next = k_ord;
                end
            end
            UPD_INS:
            begin
                if (flags.gt || (!valid_reg && is_tail))
                begin
                    valid_next = 1'b1;
                    if (left_flags.gt)
                    begin
                        sym_next = left_sym;
                        cnt_next = left_cnt;
                        ord_next = left_ord;
                    end
                    else
                    begin
                        sym_next = k_sym;
                        cnt_next = k_cnt;
                        ord_next = k_ord;
                    end
                end
            end
            UPD_CLR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
        cnt_reg <= cnt_next;
        ord_reg <= ord_next;
    end

    assign sym   = sym_reg;
    assign cnt   = cnt_reg;
    assign ord   = ord_reg;

endmodule

// ===== rtl/sfrt_checker.sv =====
// Port-level checks for the symbol frequency rank table.
// Depends on sfrt_pkg; bound to symbol_frequency_rank_table below.
module sfrt_checker
    import sfrt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  opcode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] frequency,
    input logic        valid_res,
    input logic [8:0]  distinct_count
);

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frequency) && $stable(valid_res))
        else $error("stalled result changed");

    // An accepted item blocks input for its update cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready during update");

    // A read beat yields a result once its update cycle has loaded the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_READ |=> ##1 out_valid)
        else $error("read result missing");

    // A valid entry was counted at least once
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> frequency != 24'd0 && distinct_count != 9'd0)
        else $error("valid entry with zero count");

endmodule

bind symbol_frequency_rank_table sfrt_checker u_sfrt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frequency      (frequency),
    .valid_res      (valid_res),
    .distinct_count (distinct_count)
);
